### rtl/core/gtm_pkg.sv
`timescale 1ns / 1ps
// shared types, constants and arithmetic helpers for the mercator pose unit
// no dependencies; used by the pose unit, its checker and its bench

package gtm_pkg;

    typedef logic signed [39:0] t_q30;

    localparam int TAB_LEN = 29;

    // fraction bits of the angle inputs and the trig outputs, tied to the port widths
    localparam int FRAC_BITS = 16;

    localparam t_q30 ONE_Q30     = 40'sd1073741824;
    localparam t_q30 GAIN_Q30    = 40'sd652032874;
    localparam t_q30 PI_Q30      = 40'sd3373259426;
    localparam t_q30 HALF_PI_Q30 = 40'sd1686629713;
    localparam t_q30 TWO_PI_Q30  = 40'sd6746518852;
    localparam t_q30 LN2_Q30     = 40'sd744261118;

    localparam logic signed [51:0] DEG2RAD_Q32 = 52'sd74961321;
    localparam logic signed [65:0] EARTH_R     = 66'sd6378137;

    // floor(2^56 / two_pi_q30): reciprocal for the heading range reduction
    localparam logic [23:0] INV_TWO_PI = 24'((64'd1 << 56) / 64'd6746518852);

    localparam logic signed [43:0] OUT_MAX = 44'sd8589934591;
    localparam logic signed [43:0] OUT_MIN = -44'sd8589934592;

    localparam logic REG_MERCATOR_SCALE = 1'b0;
    localparam logic [16:0] SCALE_RESET = 17'd65536;

    localparam t_q30 ATAN_TAB [0:TAB_LEN-1] = '{
        40'sd843314857, 40'sd497837829, 40'sd263043837, 40'sd133525159, 40'sd67021687,
        40'sd33543516, 40'sd16775851, 40'sd8388437, 40'sd4194283, 40'sd2097149,
        40'sd1048576, 40'sd524288, 40'sd262144, 40'sd131072, 40'sd65536, 40'sd32768,
        40'sd16384, 40'sd8192, 40'sd4096, 40'sd2048, 40'sd1024, 40'sd512, 40'sd256,
        40'sd128, 40'sd64, 40'sd32, 40'sd16, 40'sd8, 40'sd4
    };

    localparam t_q30 ATANH_TAB [0:TAB_LEN-1] = '{
        40'sd0, 40'sd589812981, 40'sd274247419, 40'sd134923406, 40'sd67196451,
        40'sd33565361, 40'sd16778582, 40'sd8388779, 40'sd4194325, 40'sd2097155,
        40'sd1048576, 40'sd524288, 40'sd262144, 40'sd131072, 40'sd65536, 40'sd32768,
        40'sd16384, 40'sd8192, 40'sd4096, 40'sd2048, 40'sd1024, 40'sd512, 40'sd256,
        40'sd128, 40'sd64, 40'sd32, 40'sd16, 40'sd8, 40'sd4
    };

    typedef struct packed {
        t_q30 ang;
        logic neg;
    } t_fold;

    typedef struct packed {
        logic signed [17:0] cos_h;
        logic signed [17:0] sin_h;
        t_q30               lon_rad;
        logic               lat_pos;
        logic               lat_neg;
        logic               up_bad;
        logic               dn_bad;
    } t_side;

    // wrap to +-pi, then fold into +-pi/2 with a sign flip of the result
    function automatic t_fold fold_angle(t_q30 a);
        t_fold f;
        t_q30  v;
        v = a;
        if (v > PI_Q30) begin
            v = v - TWO_PI_Q30;
        end else if (v < -PI_Q30) begin
            v = v + TWO_PI_Q30;
        end
        f.neg = 1'b0;
        if (v > HALF_PI_Q30) begin
            v = v - PI_Q30;
            f.neg = 1'b1;
        end else if (v < -HALF_PI_Q30) begin
            v = v + PI_Q30;
            f.neg = 1'b1;
        end
        f.ang = v;
        return f;
    endfunction

    function automatic logic signed [17:0] trig_out(t_q30 v, int fb);
        t_q30 one;
        t_q30 r;
        one = 40'sd1 <<< fb;
        r = (v + (40'sd1 <<< (29 - fb))) >>> (30 - fb);
        if (r > one) begin
            r = one;
        end else if (r < -one) begin
            r = -one;
        end
        return r[17:0];
    endfunction

    function automatic logic [6:0] bit_len(logic [39:0] u);
        logic [6:0] n;
        n = 7'd0;
        for (int k = 0; k < 40; k++) begin
            if (u[k]) begin
                n = 7'(k + 1);
            end
        end
        return n;
    endfunction

    // hyperbolic iteration index per step, iterations 4 and 13 run twice
    function automatic int hyp_iter(int k);
        int r;
        if (k < 4) begin
            r = k + 1;
        end else if (k == 4) begin
            r = 4;
        end else if (k <= 13) begin
            r = k;
        end else if (k == 14) begin
            r = 13;
        end else begin
            r = k - 1;
        end
        return r;
    endfunction

    function automatic logic signed [33:0] sat34(logic signed [43:0] v);
        logic signed [43:0] r;
        r = v;
        if (r > OUT_MAX) begin
            r = OUT_MAX;
        end else if (r < OUT_MIN) begin
            r = OUT_MIN;
        end
        return r[33:0];
    endfunction

endpackage

### rtl/core/gtm_if.sv
`timescale 1ns / 1ps
// valid/ready channels for the fix words in and the pose words out
// no dependencies

interface gtm_in_if;
    logic                valid;
    logic                ready;
    logic signed [18:0]  heading_rad;
    logic signed [23:0]  latitude_deg;
    logic signed [24:0]  longitude_deg;

    modport source (output valid, heading_rad, latitude_deg, longitude_deg, input ready);
    modport sink (input valid, heading_rad, latitude_deg, longitude_deg, output ready);
endinterface

interface gtm_out_if;
    logic                valid;
    logic                ready;
    logic signed [17:0]  cos_heading;
    logic signed [17:0]  sin_heading;
    logic signed [33:0]  east_offset;
    logic signed [33:0]  north_offset;
    logic                north_saturated;

    modport source (output valid, cos_heading, sin_heading, east_offset, north_offset,
                    north_saturated, input ready);
    modport sink (input valid, cos_heading, sin_heading, east_offset, north_offset,
                  north_saturated, output ready);
endinterface

### rtl/core/gps_to_mercator_pose_unit.sv
`timescale 1ns / 1ps
// Mercator pose unit: takes one fix word (yaw, latitude, longitude) per cycle
// unless stalled and returns cos/sin of yaw plus the scaled Mercator east and
// north offsets. Fully pipelined: a new word is taken every cycle while the
// output is free, with one register per circular CORDIC iteration and per
// hyperbolic CORDIC step of the two log units. The whole pipeline holds only
// while a finished word waits at the output. Latitudes at or past the poles,
// a non-positive 1 +- sin(lat) and Mercator values past +-pi clip the north
// offset and raise north_saturated. The scale register (Q1.16, reset 1.0)
// sits at APB address 0; write it only while the pipeline is empty.
// depends on gtm_pkg and gtm_if

module gps_to_mercator_pose_unit #(
    parameter int CORDIC_STAGES = 18
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    gtm_in_if.sink          i_in,
    gtm_out_if.source       o_out,
    input  logic            psel,
    input  logic            penable,
    input  logic            pwrite,
    input  logic [2:0]      paddr,
    input  logic [31:0]     pwdata,
    output logic [31:0]     prdata,
    output logic            pready
);

    localparam int FRAC_BITS = gtm_pkg::FRAC_BITS;
    localparam int NC      = (CORDIC_STAGES < gtm_pkg::TAB_LEN - 1) ?
                             CORDIC_STAGES : gtm_pkg::TAB_LEN - 1;
    localparam int NH      = CORDIC_STAGES + 1 + ((CORDIC_STAGES >= 13) ? 1 : 0);
    localparam int NSTG    = NC + NH + 11;
    localparam int SH      = 30 - FRAC_BITS;
    localparam logic signed [31:0] LAT_LIM = 32'sd90 <<< FRAC_BITS;

    // ---------------- configuration ----------------
    logic [16:0] r_scale;
    logic        w_cfg_wr;

    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite && (paddr[2] == gtm_pkg::REG_MERCATOR_SCALE);
    assign prdata   = (paddr[2] == gtm_pkg::REG_MERCATOR_SCALE) ? 32'(r_scale) : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scale <= gtm_pkg::SCALE_RESET;
        end else if (w_cfg_wr) begin
            r_scale <= pwdata[16:0];
        end
    end

    // ---------------- flow control ----------------
    logic            w_adv;
    logic [NSTG-1:0] r_vld;

    assign w_adv       = !r_vld[NSTG-1] || o_out.ready;
    assign i_in.ready  = w_adv;
    assign o_out.valid = r_vld[NSTG-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_adv) begin
            r_vld <= {r_vld[NSTG-2:0], i_in.valid};
        end
    end

    // ---------------- stage 1: quotient estimate, degree products ----------------
    gtm_pkg::t_q30      w_a;
    logic [39:0]        w_abs;
    logic [47:0]        w_qp;
    logic signed [51:0] w_latp;
    logic signed [51:0] w_lonp;

    logic [39:0]        r1_abs;
    logic               r1_neg;
    logic [4:0]         r1_q;
    logic signed [51:0] r1_latp;
    logic signed [51:0] r1_lonp;
    logic               r1_latpos;
    logic               r1_latneg;

    assign w_a    = 40'(i_in.heading_rad) <<< SH;
    assign w_abs  = w_a[39] ? 40'(-w_a) : 40'(w_a);
    assign w_qp   = {24'd0, w_abs[39:16]} * {24'd0, gtm_pkg::INV_TWO_PI};
    assign w_latp = 52'(i_in.latitude_deg) * gtm_pkg::DEG2RAD_Q32;
    assign w_lonp = 52'(i_in.longitude_deg) * gtm_pkg::DEG2RAD_Q32;

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r1_abs    <= w_abs;
            r1_neg    <= w_a[39];
            r1_q      <= w_qp[44:40];
            r1_latp   <= w_latp;
            r1_lonp   <= w_lonp;
            r1_latpos <= 32'(i_in.latitude_deg) >= LAT_LIM;
            r1_latneg <= 32'(i_in.latitude_deg) <= -LAT_LIM;
        end
    end

    // ---------------- stage 2: remainder mod 2pi, degree rounding ----------------
    logic [39:0]        w_qt;
    logic [39:0]        w_r0;
    logic [39:0]        w_r;
    gtm_pkg::t_q30      w_am;
    gtm_pkg::t_side     w_s2;

    gtm_pkg::t_q30      r2_am;
    gtm_pkg::t_q30      r2_latr;
    gtm_pkg::t_side     r2_side;

    assign w_qt = 40'(r1_q) * $unsigned(gtm_pkg::TWO_PI_Q30);
    assign w_r0 = r1_abs - w_qt;
    // estimate may be one short of the true quotient
    assign w_r  = (w_r0 >= $unsigned(gtm_pkg::TWO_PI_Q30)) ?
                  w_r0 - $unsigned(gtm_pkg::TWO_PI_Q30) : w_r0;
    assign w_am = r1_neg ? -$signed(w_r) : $signed(w_r);

    always_comb begin
        w_s2         = '0;
        w_s2.lon_rad = 40'((r1_lonp + (52'sd1 <<< (FRAC_BITS + 1))) >>> (FRAC_BITS + 2));
        w_s2.lat_pos = r1_latpos;
        w_s2.lat_neg = r1_latneg;
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r2_am   <= w_am;
            r2_latr <= 40'((r1_latp + (52'sd1 <<< (FRAC_BITS + 1))) >>> (FRAC_BITS + 2));
            r2_side <= w_s2;
        end
    end

    // ---------------- stage 3 and circular cordic ----------------
    gtm_pkg::t_fold w_fh;
    gtm_pkg::t_fold w_fl;

    gtm_pkg::t_q30  r_hx [0:NC];
    gtm_pkg::t_q30  r_hy [0:NC];
    gtm_pkg::t_q30  r_hz [0:NC];
    gtm_pkg::t_q30  r_lx [0:NC];
    gtm_pkg::t_q30  r_ly [0:NC];
    gtm_pkg::t_q30  r_lz [0:NC];
    logic           r_hneg [0:NC];
    logic           r_lneg [0:NC];
    gtm_pkg::t_side r_cs [0:NC];

    assign w_fh = gtm_pkg::fold_angle(r2_am);
    assign w_fl = gtm_pkg::fold_angle(r2_latr);

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_hx[0]   <= gtm_pkg::GAIN_Q30;
            r_hy[0]   <= '0;
            r_hz[0]   <= w_fh.ang;
            r_hneg[0] <= w_fh.neg;
            r_lx[0]   <= gtm_pkg::GAIN_Q30;
            r_ly[0]   <= '0;
            r_lz[0]   <= w_fl.ang;
            r_lneg[0] <= w_fl.neg;
            r_cs[0]   <= r2_side;
        end
    end

    for (genvar j = 0; j < NC; j++) begin : g_circ
        always_ff @(posedge i_clk) begin
            if (w_adv) begin
                if (!r_hz[j][39]) begin
                    r_hx[j+1] <= r_hx[j] - (r_hy[j] >>> j);
                    r_hy[j+1] <= r_hy[j] + (r_hx[j] >>> j);
                    r_hz[j+1] <= r_hz[j] - gtm_pkg::ATAN_TAB[j];
                end else begin
                    r_hx[j+1] <= r_hx[j] + (r_hy[j] >>> j);
                    r_hy[j+1] <= r_hy[j] - (r_hx[j] >>> j);
                    r_hz[j+1] <= r_hz[j] + gtm_pkg::ATAN_TAB[j];
                end
                if (!r_lz[j][39]) begin
                    r_lx[j+1] <= r_lx[j] - (r_ly[j] >>> j);
                    r_ly[j+1] <= r_ly[j] + (r_lx[j] >>> j);
                    r_lz[j+1] <= r_lz[j] - gtm_pkg::ATAN_TAB[j];
                end else begin
                    r_lx[j+1] <= r_lx[j] + (r_ly[j] >>> j);
                    r_ly[j+1] <= r_ly[j] - (r_lx[j] >>> j);
                    r_lz[j+1] <= r_lz[j] + gtm_pkg::ATAN_TAB[j];
                end
                r_hneg[j+1] <= r_hneg[j];
                r_lneg[j+1] <= r_lneg[j];
                r_cs[j+1]   <= r_cs[j];
            end
        end
    end

    // ---------------- stage 4: trig outputs, 1 +- sin(lat) ----------------
    gtm_pkg::t_q30  w_hc;
    gtm_pkg::t_q30  w_hs;
    gtm_pkg::t_q30  w_ls;
    gtm_pkg::t_q30  w_up;
    gtm_pkg::t_q30  w_dn;
    gtm_pkg::t_side w_s4;

    gtm_pkg::t_q30  r4_up;
    gtm_pkg::t_q30  r4_dn;
    gtm_pkg::t_side r4_side;

    assign w_hc = r_hneg[NC] ? -r_hx[NC] : r_hx[NC];
    assign w_hs = r_hneg[NC] ? -r_hy[NC] : r_hy[NC];
    assign w_ls = r_lneg[NC] ? -r_ly[NC] : r_ly[NC];
    assign w_up = gtm_pkg::ONE_Q30 + w_ls;
    assign w_dn = gtm_pkg::ONE_Q30 - w_ls;

    always_comb begin
        w_s4        = r_cs[NC];
        w_s4.cos_h  = gtm_pkg::trig_out(w_hc, FRAC_BITS);
        w_s4.sin_h  = gtm_pkg::trig_out(w_hs, FRAC_BITS);
        w_s4.up_bad = (w_up <= 0);
        w_s4.dn_bad = (w_dn <= 0);
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r4_up   <= w_up;
            r4_dn   <= w_dn;
            r4_side <= w_s4;
        end
    end

    // ---------------- stage 5: leading one search ----------------
    gtm_pkg::t_q30  r5_up;
    gtm_pkg::t_q30  r5_dn;
    logic [6:0]     r5_ubl;
    logic [6:0]     r5_dbl;
    gtm_pkg::t_side r5_side;

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r5_up   <= r4_up;
            r5_dn   <= r4_dn;
            r5_ubl  <= gtm_pkg::bit_len(r4_up);
            r5_dbl  <= gtm_pkg::bit_len(r4_dn);
            r5_side <= r4_side;
        end
    end

    // ---------------- stage 6: normalize, hyperbolic cordic ----------------
    logic [39:0]    w_um;
    logic [39:0]    w_dm;

    gtm_pkg::t_q30  r_ux [0:NH];
    gtm_pkg::t_q30  r_uy [0:NH];
    gtm_pkg::t_q30  r_uz [0:NH];
    gtm_pkg::t_q30  r_dx [0:NH];
    gtm_pkg::t_q30  r_dy [0:NH];
    gtm_pkg::t_q30  r_dz [0:NH];
    logic [6:0]     r_ubl [0:NH];
    logic [6:0]     r_dbl [0:NH];
    gtm_pkg::t_side r_hs [0:NH];

    // mantissa lands in [2^30, 2^31)
    assign w_um = (r5_ubl > 7'd31) ? (r5_up >> (r5_ubl - 7'd31)) : (r5_up << (7'd31 - r5_ubl));
    assign w_dm = (r5_dbl > 7'd31) ? (r5_dn >> (r5_dbl - 7'd31)) : (r5_dn << (7'd31 - r5_dbl));

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_ux[0]  <= $signed(w_um) + gtm_pkg::ONE_Q30;
            r_uy[0]  <= $signed(w_um) - gtm_pkg::ONE_Q30;
            r_uz[0]  <= '0;
            r_dx[0]  <= $signed(w_dm) + gtm_pkg::ONE_Q30;
            r_dy[0]  <= $signed(w_dm) - gtm_pkg::ONE_Q30;
            r_dz[0]  <= '0;
            r_ubl[0] <= r5_ubl;
            r_dbl[0] <= r5_dbl;
            r_hs[0]  <= r5_side;
        end
    end

    for (genvar k = 0; k < NH; k++) begin : g_hyp
        localparam int HI = gtm_pkg::hyp_iter(k);
        always_ff @(posedge i_clk) begin
            if (w_adv) begin
                if (r_uy[k] > 0) begin
                    r_ux[k+1] <= r_ux[k] - (r_uy[k] >>> HI);
                    r_uy[k+1] <= r_uy[k] - (r_ux[k] >>> HI);
                    r_uz[k+1] <= r_uz[k] + gtm_pkg::ATANH_TAB[HI];
                end else begin
                    r_ux[k+1] <= r_ux[k] + (r_uy[k] >>> HI);
                    r_uy[k+1] <= r_uy[k] + (r_ux[k] >>> HI);
                    r_uz[k+1] <= r_uz[k] - gtm_pkg::ATANH_TAB[HI];
                end
                if (r_dy[k] > 0) begin
                    r_dx[k+1] <= r_dx[k] - (r_dy[k] >>> HI);
                    r_dy[k+1] <= r_dy[k] - (r_dx[k] >>> HI);
                    r_dz[k+1] <= r_dz[k] + gtm_pkg::ATANH_TAB[HI];
                end else begin
                    r_dx[k+1] <= r_dx[k] + (r_dy[k] >>> HI);
                    r_dy[k+1] <= r_dy[k] + (r_dx[k] >>> HI);
                    r_dz[k+1] <= r_dz[k] - gtm_pkg::ATANH_TAB[HI];
                end
                r_ubl[k+1] <= r_ubl[k];
                r_dbl[k+1] <= r_dbl[k];
                r_hs[k+1]  <= r_hs[k];
            end
        end
    end

    // ---------------- stage 7: ln = e*ln2 + 2z ----------------
    logic signed [7:0] w_ue;
    logic signed [7:0] w_de;
    gtm_pkg::t_q30     r7_lnu;
    gtm_pkg::t_q30     r7_lnd;
    gtm_pkg::t_side    r7_side;

    assign w_ue = $signed({1'b0, r_ubl[NH]}) - 8'sd31;
    assign w_de = $signed({1'b0, r_dbl[NH]}) - 8'sd31;

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r7_lnu  <= 40'(w_ue) * gtm_pkg::LN2_Q30 + (r_uz[NH] <<< 1);
            r7_lnd  <= 40'(w_de) * gtm_pkg::LN2_Q30 + (r_dz[NH] <<< 1);
            r7_side <= r_hs[NH];
        end
    end

    // ---------------- stage 8: atanh, pole handling ----------------
    gtm_pkg::t_q30  w_diff;
    gtm_pkg::t_q30  w_merc;
    logic           w_sat;

    gtm_pkg::t_q30  r8_merc;
    logic           r8_sat;
    gtm_pkg::t_side r8_side;

    assign w_diff = (r7_lnu - r7_lnd) >>> 1;

    always_comb begin
        w_merc = w_diff;
        w_sat  = 1'b1;
        priority if (r7_side.lat_pos) begin
            w_merc = gtm_pkg::PI_Q30;
        end else if (r7_side.lat_neg) begin
            w_merc = -gtm_pkg::PI_Q30;
        end else if (r7_side.dn_bad) begin
            w_merc = gtm_pkg::PI_Q30;
        end else if (r7_side.up_bad) begin
            w_merc = -gtm_pkg::PI_Q30;
        end else if (w_diff > gtm_pkg::PI_Q30) begin
            w_merc = gtm_pkg::PI_Q30;
        end else if (w_diff < -gtm_pkg::PI_Q30) begin
            w_merc = -gtm_pkg::PI_Q30;
        end else begin
            w_sat = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r8_merc <= w_merc;
            r8_sat  <= w_sat;
            r8_side <= r7_side;
        end
    end

    // ---------------- projection: scale, earth radius, clamp ----------------
    logic signed [57:0] r_pe;
    logic signed [57:0] r_pn;
    logic               r_p1_sat;
    gtm_pkg::t_side     r_p1_side;

    logic signed [41:0] w_te;
    logic signed [41:0] w_tn;
    logic signed [65:0] r_qe;
    logic signed [65:0] r_qn;
    logic               r_p2_sat;
    gtm_pkg::t_side     r_p2_side;

    logic signed [43:0] w_re;
    logic signed [43:0] w_rn;
    logic signed [17:0] r_cos;
    logic signed [17:0] r_sin;
    logic signed [33:0] r_east;
    logic signed [33:0] r_north;
    logic               r_sat;

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_pe      <= 58'($signed({1'b0, r_scale})) * 58'(r8_side.lon_rad);
            r_pn      <= 58'($signed({1'b0, r_scale})) * 58'(r8_merc);
            r_p1_sat  <= r8_sat;
            r_p1_side <= r8_side;
        end
    end

    assign w_te = 42'((r_pe + 58'sd32768) >>> 16);
    assign w_tn = 42'((r_pn + 58'sd32768) >>> 16);

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_qe      <= 66'(w_te) * gtm_pkg::EARTH_R;
            r_qn      <= 66'(w_tn) * gtm_pkg::EARTH_R;
            r_p2_sat  <= r_p1_sat;
            r_p2_side <= r_p1_side;
        end
    end

    assign w_re = 44'((r_qe + (66'sd1 <<< 21)) >>> 22);
    assign w_rn = 44'((r_qn + (66'sd1 <<< 21)) >>> 22);

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_cos   <= r_p2_side.cos_h;
            r_sin   <= r_p2_side.sin_h;
            r_east  <= gtm_pkg::sat34(w_re);
            r_north <= gtm_pkg::sat34(w_rn);
            r_sat   <= r_p2_sat;
        end
    end

    assign o_out.cos_heading     = r_cos;
    assign o_out.sin_heading     = r_sin;
    assign o_out.east_offset     = r_east;
    assign o_out.north_offset    = r_north;
    assign o_out.north_saturated = r_sat;

    // ---------------- checks ----------------
    a_ready_only_stalls_on_output: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_in.ready |-> (o_out.valid && !o_out.ready))
        else $error("input held off while output is free");

    a_stall_keeps_first_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!w_adv && r_vld[0]) |=> r_vld[0])
        else $error("word lost at pipeline entry during stall");

    a_word_moves_on: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_adv && r_vld[0]) |=> r_vld[1])
        else $error("word dropped between first stages");

    a_reset_clears_output: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out.valid)
        else $error("output valid after reset");

endmodule

### test/gps_to_mercator_pose_unit_chk.sv
`timescale 1ns / 1ps
// pose checker: watches the fix and pose channels and the apb writes, predicts each pose
// word from the accepted fix and the tracked scale, compares whole words, prints fields on a mismatch
// depends on gtm_pkg and gtm_if

module gps_to_mercator_pose_unit_chk (
    input  logic        i_clk,
    input  logic        i_rst_n,
    gtm_in_if           i_fix,
    gtm_out_if          i_pose,
    input  logic        i_psel,
    input  logic        i_penable,
    input  logic        i_pwrite,
    input  logic [2:0]  i_paddr,
    input  logic [31:0] i_pwdata,
    input  logic        i_pready,
    output int          o_errors,
    output int          o_pending,
    output int          o_checked,
    output int          o_clipped
);

    localparam int FB     = gtm_pkg::FRAC_BITS;
    localparam int STAGES = 18;

    typedef struct packed {
        logic signed [17:0] cos_h;
        logic signed [17:0] sin_h;
        logic signed [33:0] east;
        logic signed [33:0] north;
        logic               clip;
    } t_pose;

    t_pose       pose_q[$];
    logic [16:0] scale_q;

    localparam longint ATAN_C [0:28] = '{
        843314857, 497837829, 263043837, 133525159, 67021687, 33543516,
        16775851, 8388437, 4194283, 2097149, 1048576, 524288, 262144, 131072,
        65536, 32768, 16384, 8192, 4096, 2048, 1024, 512, 256, 128, 64, 32, 16, 8, 4};
    localparam longint ATANH_C [0:28] = '{
        0, 589812981, 274247419, 134923406, 67196451, 33565361, 16778582,
        8388779, 4194325, 2097155, 1048576, 524288, 262144, 131072, 65536,
        32768, 16384, 8192, 4096, 2048, 1024, 512, 256, 128, 64, 32, 16, 8, 4};

    localparam longint PI_L     = 64'sd3373259426;
    localparam longint HPI_L    = 64'sd1686629713;
    localparam longint TWOPI_L  = 64'sd6746518852;
    localparam longint ONE_L    = 64'sd1073741824;

    function automatic longint round_sh(longint v, int n);
        return (v + (64'sd1 <<< (n - 1))) >>> n;
    endfunction

    function automatic longint lim(longint v, longint lo, longint hi);
        return v < lo ? lo : (v > hi ? hi : v);
    endfunction

    function automatic void rotate_q30(longint a, output longint c, output longint s);
        longint x, y, z, nx, ny;
        logic   flip;
        x = 64'sd652032874;
        y = 0;
        flip = 1'b0;
        a = a % TWOPI_L;
        if (a > PI_L) a -= TWOPI_L;
        if (a < -PI_L) a += TWOPI_L;
        if (a > HPI_L) begin
            a -= PI_L;
            flip = 1'b1;
        end else if (a < -HPI_L) begin
            a += PI_L;
            flip = 1'b1;
        end
        z = a;
        for (int i = 0; i < STAGES && i < 28; i++) begin
            if (z >= 0) begin
                nx = x - (y >>> i); ny = y + (x >>> i); z -= ATAN_C[i];
            end else begin
                nx = x + (y >>> i); ny = y - (x >>> i); z += ATAN_C[i];
            end
            x = nx; y = ny;
        end
        c = flip ? -x : x;
        s = flip ? -y : y;
    endfunction

    // ln of v/2^30: normalize to [1,2) then hyperbolic vectoring, 4 and 13 repeated
    function automatic longint log_q30(longint v);
        longint x, y, z, nx, ny, m;
        int     bl, reps;
        bl = 0;
        z = 0;
        while (bl < 64 && (v >> bl) != 0) bl++;
        m = bl > 31 ? (v >> (bl - 31)) : (v << (31 - bl));
        x = m + ONE_L;
        y = m - ONE_L;
        for (int i = 1; i <= STAGES && i < 29; i++) begin
            reps = (i == 4 || i == 13) ? 2 : 1;
            for (int r = 0; r < reps; r++) begin
                if (y > 0) begin
                    nx = x - (y >>> i); ny = y - (x >>> i); z += ATANH_C[i];
                end else begin
                    nx = x + (y >>> i); ny = y + (x >>> i); z -= ATANH_C[i];
                end
                x = nx; y = ny;
            end
        end
        return longint'(bl - 31) * 64'sd744261118 + 2 * z;
    endfunction

    function automatic longint to_rad(longint d);
        return round_sh(d * 64'sd74961321, FB + 2);
    endfunction

    function automatic longint scaled_metres(longint r, logic [16:0] sc);
        longint t;
        t = round_sh(longint'(sc) * r, 16);
        return lim(round_sh(t * 64'sd6378137, 22), -64'sd8589934592, 64'sd8589934591);
    endfunction

    function automatic t_pose predict_pose(logic signed [18:0] hd, logic signed [23:0] lat,
                                           logic signed [24:0] lon, logic [16:0] sc);
        t_pose  p;
        longint c, s, merc, up, dn, one, pole;
        one = 64'sd1 <<< FB;
        pole = 90 * one;
        rotate_q30(longint'(hd) * (64'sd1 <<< (30 - FB)), c, s);
        p.cos_h = 18'(lim(round_sh(c, 30 - FB), -one, one));
        p.sin_h = 18'(lim(round_sh(s, 30 - FB), -one, one));
        p.east = 34'(scaled_metres(to_rad(longint'(lon)), sc));
        p.clip = 1'b0;
        if (longint'(lat) >= pole) begin
            merc = PI_L; p.clip = 1'b1;
        end else if (longint'(lat) <= -pole) begin
            merc = -PI_L; p.clip = 1'b1;
        end else begin
            rotate_q30(to_rad(longint'(lat)), c, s);
            up = ONE_L + s;
            dn = ONE_L - s;
            if (dn <= 0) begin
                merc = PI_L; p.clip = 1'b1;
            end else if (up <= 0) begin
                merc = -PI_L; p.clip = 1'b1;
            end else begin
                merc = (log_q30(up) - log_q30(dn)) >>> 1;
                if (merc > PI_L) begin
                    merc = PI_L; p.clip = 1'b1;
                end else if (merc < -PI_L) begin
                    merc = -PI_L; p.clip = 1'b1;
                end
            end
        end
        p.north = 34'(scaled_metres(merc, sc));
        return p;
    endfunction

    assign o_pending = pose_q.size();

    always @(posedge i_clk) begin
        t_pose want, got;
        if (!i_rst_n) begin
            scale_q <= gtm_pkg::SCALE_RESET;
            pose_q.delete();
            o_errors <= 0;
            o_checked <= 0;
            o_clipped <= 0;
        end else begin
            if (i_psel && i_penable && i_pwrite && i_pready &&
                i_paddr[2] == gtm_pkg::REG_MERCATOR_SCALE) begin
                scale_q <= i_pwdata[16:0];
            end
            if (i_fix.valid && i_fix.ready) begin
                pose_q.insert(pose_q.size(),
                              predict_pose(i_fix.heading_rad, i_fix.latitude_deg,
                                           i_fix.longitude_deg, scale_q));
            end
            if (i_pose.valid && i_pose.ready) begin
                got = '{i_pose.cos_heading, i_pose.sin_heading, i_pose.east_offset,
                        i_pose.north_offset, i_pose.north_saturated};
                if (pose_q.size() == 0) begin
                    if (o_errors < 10) $display("pose word with nothing expected: %p", got);
                    o_errors <= o_errors + 1;
                end else begin
                    want = pose_q.pop_front();
                    o_checked <= o_checked + 1;
                    o_clipped <= o_clipped + want.clip;
                    if (got !== want) begin
                        if (o_errors < 10) begin
                            $display("pose mismatch cos %0d/%0d sin %0d/%0d",
                                     want.cos_h, got.cos_h, want.sin_h, got.sin_h);
                            $display("  east %0d/%0d north %0d/%0d clip %0d/%0d",
                                     want.east, got.east, want.north, got.north,
                                     want.clip, got.clip);
                        end
                        o_errors <= o_errors + 1;
                    end
                end
            end
        end
    end
endmodule

### test/gps_to_mercator_pose_unit_tb.sv
`timescale 1ns / 1ps
// top of the mercator pose unit bench: clock, reset, apb scale writes, fix stimulus
// with random gaps and output stalls; depends on gtm_pkg, gtm_if, the unit and the checker

module gps_to_mercator_pose_unit_tb;

    localparam logic [2:0] SCALE_ADDR = {gtm_pkg::REG_MERCATOR_SCALE, 2'b00};
    // first address past the register list
    localparam logic [2:0] SPARE_ADDR = 3'd4;

    logic        i_clk;
    logic        i_rst_n;
    logic        psel, penable, pwrite, pready;
    logic [2:0]  paddr;
    logic [31:0] pwdata, prdata;
    logic        calm;
    int          errors, pending, checked, clipped;

    gtm_in_if  fix_if ();
    gtm_out_if pose_if ();

    gps_to_mercator_pose_unit u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (fix_if),
        .o_out   (pose_if),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    gps_to_mercator_pose_unit_chk u_chk (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_fix     (fix_if),
        .i_pose    (pose_if),
        .i_psel    (psel),
        .i_penable (penable),
        .i_pwrite  (pwrite),
        .i_paddr   (paddr),
        .i_pwdata  (pwdata),
        .i_pready  (pready),
        .o_errors  (errors),
        .o_pending (pending),
        .o_checked (checked),
        .o_clipped (clipped)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #5ms;
        $display("timeout");
        $display("gps_to_mercator_pose_unit_tb NOT OK");
        $finish;
    end

    always @(posedge i_clk) begin
        pose_if.ready <= calm ? 1'b1 : ($urandom_range(99) >= 30);
    end

    task automatic apb_write(input logic [2:0] addr, input logic [31:0] data);
        @(posedge i_clk);
        psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1; paddr <= addr; pwdata <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    endtask

    task automatic send_fix(input logic [18:0] hd, input logic [23:0] lat,
                            input logic [24:0] lon);
        if (!calm && $urandom_range(99) < 30) begin
            fix_if.valid <= 1'b0;
            repeat ($urandom_range(4, 1)) @(posedge i_clk);
        end
        fix_if.valid <= 1'b1;
        fix_if.heading_rad <= hd;
        fix_if.latitude_deg <= lat;
        fix_if.longitude_deg <= lon;
        @(posedge i_clk);
        while (!fix_if.ready) @(posedge i_clk);
    endtask

    // idle the input and let the pipeline empty before touching the scale
    task automatic drain;
        fix_if.valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (60) @(posedge i_clk);
    endtask

    task automatic random_fixes(input int n);
        logic [18:0] hd;
        logic [23:0] lat;
        logic [24:0] lon;
        for (int k = 0; k < n; k++) begin
            if ($urandom_range(9) == 0) begin
                // raw words cover every bit and the out of range corners
                hd = 19'($urandom); lat = 24'($urandom); lon = 25'($urandom);
            end else begin
                hd = 19'($urandom_range(411774) - 205887);
                lat = $urandom_range(3) == 0
                    ? 24'($urandom_range(655360) + 5242880)
                    : 24'($urandom_range(11796480) - 5898240);
                if ($urandom_range(1)) lat = -lat;
                lon = 25'($urandom_range(23592960) - 11796480);
            end
            send_fix(hd, lat, lon);
        end
    endtask

    int dir_hd  [12] = '{0, 205887, -205887, 262143, -262144, 102944,
                         -102944, 205888, 1, -1, 51472, 154416};
    int dir_lat [12] = '{0, 5898240, -5898240, 8388607, -8388608, 5573836,
                         -5573836, 5897584, -5897584, 5898239, 1, -1};
    int dir_lon [12] = '{0, 11796480, -11796480, 16777215, -16777216, 1,
                         -1, 5898240, -5898240, 11796481, 123456, -654321};
    int scales  [6]  = '{0, 131071, 32768, 65535, 1, 45875};

    initial begin
        i_rst_n = 1'b0;
        calm = 1'b0;
        psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
        fix_if.valid = 1'b0;
        fix_if.heading_rad = '0; fix_if.latitude_deg = '0; fix_if.longitude_deg = '0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (int k = 0; k < 12; k++) begin
            send_fix(19'(dir_hd[k]), 24'(dir_lat[k]), 25'(dir_lon[k]));
        end
        drain;
        // write to an address past the register list must change nothing
        apb_write(SPARE_ADDR, 32'd1234);
        apb_write(SCALE_ADDR, 32'(gtm_pkg::SCALE_RESET));
        random_fixes(200);
        calm = 1'b1;
        random_fixes(200);
        calm = 1'b0;
        foreach (scales[s]) begin
            drain;
            apb_write(SCALE_ADDR, 32'(scales[s]));
            if (s < 2) begin
                for (int k = 0; k < 12; k++) begin
                    send_fix(19'(dir_hd[k]), 24'(dir_lat[k]), 25'(dir_lon[k]));
                end
            end
            random_fixes(180);
        end
        drain;
        apb_write(SCALE_ADDR, 32'(gtm_pkg::SCALE_RESET));
        random_fixes(100);

        drain;
        $display("checked %0d pose words, %0d with north clipped, over %0d scale settings",
                 checked, clipped, 8);
        if (errors == 0) begin
            $display("gps_to_mercator_pose_unit_tb OK");
        end else begin
            $display("%0d mismatches", errors);
            $display("gps_to_mercator_pose_unit_tb NOT OK");
        end
        $finish;
    end
endmodule
